// ----- rtl/core/png_cp_pkg.sv -----
// ----------------------------------------------------------------------------
// png_cp_pkg
// Shared types, record codes and the byte-wide CRC-32 update for the PNG
// chunk parser.
// ----------------------------------------------------------------------------
package png_cp_pkg;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_BAD_SIG = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } t_in_beat;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [15:0] chunk_index;
        logic [31:0] chunk_type;
        logic [31:0] chunk_length;
        logic        crc_ok;
    } t_result;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
    localparam logic [15:0] INDEX_MAX = 16'hFFFF;

    localparam logic [7:0] PNG_SIG [8] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/png_cp_if.sv -----
// ----------------------------------------------------------------------------
// png_cp_if
// Valid/ready channels for the PNG chunk parser: byte input and records out.
// ----------------------------------------------------------------------------
interface png_cp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       file_start;

    modport source (output valid, output in_byte, output file_start, input ready);
    modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

interface png_cp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [15:0] chunk_index;
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic        crc_ok;

    modport source (output valid, output result_kind, output data_byte,
                    output chunk_index, output chunk_type, output chunk_length,
                    output crc_ok, input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input chunk_index, input chunk_type, input chunk_length,
                    input crc_ok, output ready);
endinterface

// ----- rtl/core/png_chunk_parser_crc_check.sv -----
// ----------------------------------------------------------------------------
// png_chunk_parser_crc_check
// PNG byte stream parser: signature check, chunk walk, CRC-32 verdict.
//
//   channel  dir  beat
//   i_in     in   one file byte plus file_start flag
//   o_out    out  one record: data byte, chunk summary or bad signature
//
// One byte per cycle while o_out is not stalled; beats are registered at
// the input and records at the output. The CRC update is byte-wide XOR logic.
// Reset (i_rst_n low, synchronous) puts the parser in the signature phase.
// An output stall backs up into the input register; i_in.ready falls only
// when both registers are full.
// ----------------------------------------------------------------------------
module png_chunk_parser_crc_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    png_cp_in_if.sink     i_in,
    png_cp_out_if.source  o_out
);
    import png_cp_pkg::*;

    t_in_beat in_beat;
    t_in_beat reg_beat;
    logic     reg_valid;
    logic     take;
    logic     out_can_take;
    logic     res_valid;
    t_result  res;
    t_result  out_res;

    assign in_beat.in_byte    = i_in.in_byte;
    assign in_beat.file_start = i_in.file_start;

    png_cp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_beat  (in_beat),
        .i_take  (take),
        .o_valid (reg_valid),
        .o_beat  (reg_beat)
    );

    png_cp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (reg_valid),
        .i_beat      (reg_beat),
        .i_out_ready (out_can_take),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    png_cp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (res_valid),
        .i_res      (res),
        .o_can_take (out_can_take),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_res      (out_res)
    );

    assign o_out.result_kind  = out_res.kind;
    assign o_out.data_byte    = out_res.data_byte;
    assign o_out.chunk_index  = out_res.chunk_index;
    assign o_out.chunk_type   = out_res.chunk_type;
    assign o_out.chunk_length = out_res.chunk_length;
    assign o_out.crc_ok       = out_res.crc_ok;

endmodule

// ----- rtl/core/png_cp_in_reg.sv -----
// ----------------------------------------------------------------------------
// png_cp_in_reg
// Input register: holds one byte beat until the parser takes it.
// ----------------------------------------------------------------------------
module png_cp_in_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  png_cp_pkg::t_in_beat  i_beat,
    input  logic                  i_take,
    output logic                  o_valid,
    output png_cp_pkg::t_in_beat  o_beat
);
    import png_cp_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

// ----- rtl/core/png_cp_parser.sv -----
// ----------------------------------------------------------------------------
// png_cp_parser
// Signature check, chunk field walk and running CRC, one byte per beat.
// ----------------------------------------------------------------------------
module png_cp_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  png_cp_pkg::t_in_beat  i_beat,
    input  logic                  i_out_ready,
    output logic                  o_take,
    output logic                  o_res_valid,
    output png_cp_pkg::t_result   o_res
);
    import png_cp_pkg::*;

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_DEAD = 3'd5
    } t_phase;

    t_phase      r_phase,  n_phase,  c_phase;
    logic [2:0]  r_cnt,    n_cnt,    c_cnt;
    logic [31:0] r_len,    n_len,    c_len;
    logic [31:0] r_rem,    n_rem,    c_rem;
    logic [31:0] r_type,   n_type,   c_type;
    logic [31:0] r_crc,    n_crc,    c_crc;
    logic [31:0] r_stored, n_stored, c_stored;
    logic [15:0] r_idx,    n_idx,    c_idx;
    logic        r_sig_bad, n_sig_bad, c_sig_bad;
    logic        emit;
    t_result     res;
    logic [7:0]  b;

    assign b           = i_beat.in_byte;
    assign o_take      = i_valid && i_out_ready;
    assign o_res_valid = o_take && emit;
    assign o_res       = res;

    always_comb begin
        c_phase   = r_phase;
        c_cnt     = r_cnt;
        c_len     = r_len;
        c_rem     = r_rem;
        c_type    = r_type;
        c_crc     = r_crc;
        c_stored  = r_stored;
        c_idx     = r_idx;
        c_sig_bad = r_sig_bad;
        if (i_beat.file_start) begin
            c_phase   = PH_SIG;
            c_cnt     = '0;
            c_len     = '0;
            c_rem     = '0;
            c_type    = '0;
            c_crc     = CRC_ONES;
            c_stored  = '0;
            c_idx     = '0;
            c_sig_bad = 1'b0;
        end

        n_phase   = c_phase;
        n_cnt     = c_cnt;
        n_len     = c_len;
        n_rem     = c_rem;
        n_type    = c_type;
        n_crc     = c_crc;
        n_stored  = c_stored;
        n_idx     = c_idx;
        n_sig_bad = c_sig_bad;
        emit      = 1'b0;

        res.kind         = KIND_DATA;
        res.data_byte    = '0;
        res.chunk_index  = c_idx;
        res.chunk_type   = c_type;
        res.chunk_length = c_len;
        res.crc_ok       = 1'b0;

        unique case (c_phase)
            PH_SIG: begin
                n_sig_bad = c_sig_bad || (b != PNG_SIG[c_cnt]);
                n_cnt     = c_cnt + 3'd1;
                if (c_cnt == 3'd7) begin
                    n_cnt = '0;
                    if (n_sig_bad) begin
                        n_phase          = PH_DEAD;
                        emit             = 1'b1;
                        res.kind         = KIND_BAD_SIG;
                        res.chunk_index  = '0;
                        res.chunk_type   = '0;
                        res.chunk_length = '0;
                    end else begin
                        n_phase = PH_LEN;
                        n_len   = '0;
                    end
                end
            end
            PH_LEN: begin
                n_len = {c_len[23:0], b};
                n_cnt = c_cnt + 3'd1;
                if (c_cnt == 3'd3) begin
                    n_cnt   = '0;
                    n_rem   = n_len;
                    n_type  = '0;
                    n_crc   = CRC_ONES;
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type = {c_type[23:0], b};
                n_crc  = crc_byte(c_crc, b);
                n_cnt  = c_cnt + 3'd1;
                if (c_cnt == 3'd3) begin
                    n_cnt    = '0;
                    n_stored = '0;
                    n_phase  = (c_rem == '0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA: begin
                n_crc         = crc_byte(c_crc, b);
                emit          = 1'b1;
                res.data_byte = b;
                n_rem         = c_rem - 32'd1;
                if (c_rem == 32'd1) begin
                    n_stored = '0;
                    n_cnt    = '0;
                    n_phase  = PH_CRC;
                end
            end
            PH_CRC: begin
                n_stored = {c_stored[23:0], b};
                n_cnt    = c_cnt + 3'd1;
                if (c_cnt == 3'd3) begin
                    emit       = 1'b1;
                    res.kind   = KIND_SUMMARY;
                    res.crc_ok = ((c_crc ^ CRC_ONES) == n_stored);
                    if (c_idx != INDEX_MAX) begin
                        n_idx = c_idx + 16'd1;
                    end
                    n_cnt   = '0;
                    n_len   = '0;
                    n_phase = PH_LEN;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIG;
            r_cnt     <= '0;
            r_len     <= '0;
            r_rem     <= '0;
            r_type    <= '0;
            r_crc     <= CRC_ONES;
            r_stored  <= '0;
            r_idx     <= '0;
            r_sig_bad <= 1'b0;
        end else if (o_take) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_len     <= n_len;
            r_rem     <= n_rem;
            r_type    <= n_type;
            r_crc     <= n_crc;
            r_stored  <= n_stored;
            r_idx     <= n_idx;
            r_sig_bad <= n_sig_bad;
        end
    end

endmodule

// ----- rtl/core/png_cp_out_reg.sv -----
// ----------------------------------------------------------------------------
// png_cp_out_reg
// Result register: holds one record until the sink takes it.
// ----------------------------------------------------------------------------
module png_cp_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  png_cp_pkg::t_result  i_res,
    output logic                 o_can_take,
    output logic                 o_valid,
    input  logic                 i_ready,
    output png_cp_pkg::t_result  o_res
);
    import png_cp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule
